// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the GPIO register block RTL.
// Each macro is clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent on one edge, consequent on the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/gpiorf_pkg.sv =====
// Shared types and constants for the GPIO bank register block.
// No dependencies; imported by gpiorf_regs and gpio_bank_register_file.
package gpiorf_pkg;

	localparam int NUM_BANKS  = 4;
	localparam int BANK_W     = 2;
	localparam int BANK_IDX_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
	localparam int PINS       = 8;

	localparam logic [5:0] REG_TRIG_LEVEL = 6'h00;
	localparam logic [5:0] REG_TRIG_TYPE  = 6'h04;
	localparam logic [5:0] REG_IRQ_ENABLE = 6'h08;
	localparam logic [5:0] REG_IRQ_STATUS = 6'h0C;
	localparam logic [5:0] REG_VALUE      = 6'h10;
	localparam logic [5:0] REG_DIRECTION  = 6'h18;
	localparam logic [5:0] REG_PULL       = 6'h1C;

	localparam logic [2:0] ACCESS_SIZE_OK = 3'd2;

	typedef enum logic {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_WIDTH  = 2'd1,
		ST_OFFSET = 2'd2
	} status_t;

	typedef struct packed {
		logic [BANK_W-1:0] bank;
		opcode_t           opcode;
		logic [5:0]        offset;
		logic [2:0]        access_size;
		logic [15:0]       write_data;
	} req_t;

	typedef struct packed {
		logic [PINS-1:0] read_data;
		status_t         status;
		logic            arm_warning;
	} rsp_t;

endpackage

// ===== hdl/gpio_bank_register_file.sv =====
// Top level of the GPIO bank register block: request register, result register.
// Depends on gpiorf_pkg, gpiorf_regs and assert_macros.svh.
//
// Usage:
//  - Requests come in on s_axis (tdata: bank, offset, access_size, write_data;
//    tuser: opcode). Results leave on m_axis (tdata: read_data; tuser: status,
//    arm_warning). One result per request, in order.
//  - An accepted request sits in the request register; once the result
//    register is free or being drained, the register file is read or written in
//    one decode pass in gpiorf_regs and the result is registered, valid on
//    m_axis from then on.
//  - Throughput is one request per cycle while m_axis_tready is high.
//  - If the receiver stalls, the result holds on m_axis, the pending request
//    waits in the request register, and s_axis_tready drops once both are full.
//  - Reset (arst_n low) empties both registers and clears every bank register
//    and the per-bank arming flags to zero.
`include "assert_macros.svh"

module gpio_bank_register_file (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // bank[1:0], offset[7:2], access_size[10:8],
	                                   // write_data[26:11], zero pad
	input  logic        s_axis_tuser,  // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // read_data
	output logic [2:0]  m_axis_tuser   // status[1:0], arm_warning[2]
);
	import gpiorf_pkg::*;

	req_t req_in, req_s1;
	logic valid_s1;
	rsp_t rsp, rsp_q;
	logic out_valid_q;
	logic advance;

	assign req_in = '{bank:        s_axis_tdata[1:0],
	                  opcode:      opcode_t'(s_axis_tuser),
	                  offset:      s_axis_tdata[7:2],
	                  access_size: s_axis_tdata[10:8],
	                  write_data:  s_axis_tdata[26:11]};

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	gpiorf_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.req    (req_s1),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) req_s1 <= req_in;
		if (advance) rsp_q <= rsp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = rsp_q.read_data;
	assign m_axis_tuser  = {rsp_q.arm_warning, rsp_q.status};

	// an empty output side never blocks the request side
	`ASSERT_ALWAYS(a_ready_free, out_valid_q || s_axis_tready, "input stalled, no result held")
	// a stalled result is not overwritten
	`ASSERT_ALWAYS(a_no_clobber, !(out_valid_q && !m_axis_tready && advance), "result overwritten")
	// failed accesses report zero data
	`ASSERT_ALWAYS(a_err_zero, !out_valid_q || rsp_q.status == ST_OK || ~|rsp_q.read_data, "error data")

endmodule

// ===== hdl/gpiorf_regs.sv =====
// Per-bank GPIO register storage, address decode and arming tracker.
// Depends on gpiorf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gpiorf_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  gpiorf_pkg::req_t req,
	output gpiorf_pkg::rsp_t rsp
);
	import gpiorf_pkg::*;

	logic [PINS-1:0] value_q     [NUM_BANKS];
	logic [PINS-1:0] direction_q [NUM_BANKS];
	logic [PINS-1:0] pull_q      [NUM_BANKS];
	logic [PINS-1:0] irq_en_q    [NUM_BANKS];
	logic [PINS-1:0] trig_lvl_q  [NUM_BANKS];
	logic [PINS-1:0] trig_type_q [NUM_BANKS];
	logic [NUM_BANKS-1:0] arm_seen_q;

	logic [BANK_IDX_W-1:0] idx;
	logic                  bank_ok;
	logic [PINS-1:0]       lo, mask;
	logic we_value, we_dir, we_pull, we_irq, we_lvl, we_type, arm_try;

	assign idx     = BANK_IDX_W'(req.bank);
	assign bank_ok = int'(req.bank) < NUM_BANKS;
	assign lo      = req.write_data[PINS-1:0];
	assign mask    = req.write_data[15:8];

	always_comb begin
		rsp      = '{read_data: '0, status: ST_OK, arm_warning: 1'b0};
		we_value = 1'b0;
		we_dir   = 1'b0;
		we_pull  = 1'b0;
		we_irq   = 1'b0;
		we_lvl   = 1'b0;
		we_type  = 1'b0;
		arm_try  = 1'b0;
		if (req.access_size != ACCESS_SIZE_OK) begin
			rsp.status = ST_WIDTH;
		end else if (!bank_ok) begin
			rsp.status = ST_OFFSET;
		end else if (req.opcode == OP_READ) begin
			unique case (req.offset)
				REG_VALUE:      rsp.read_data = value_q[idx];
				REG_DIRECTION:  rsp.read_data = direction_q[idx];
				REG_PULL:       rsp.read_data = pull_q[idx];
				REG_IRQ_ENABLE: rsp.read_data = irq_en_q[idx];
				REG_TRIG_LEVEL: rsp.read_data = trig_lvl_q[idx];
				REG_TRIG_TYPE:  rsp.read_data = trig_type_q[idx];
				REG_IRQ_STATUS: rsp.read_data = '0;
				default:        rsp.status = ST_OFFSET;
			endcase
		end else begin
			unique case (req.offset)
				REG_VALUE:      we_value = 1'b1;
				REG_DIRECTION:  we_dir = 1'b1;
				REG_PULL:       we_pull = 1'b1;
				REG_IRQ_ENABLE: begin
					we_irq  = 1'b1;
					arm_try = lo != '0;
				end
				REG_TRIG_LEVEL: begin
					we_lvl  = 1'b1;
					arm_try = irq_en_q[idx] != '0;
				end
				REG_TRIG_TYPE: begin
					we_type = 1'b1;
					arm_try = irq_en_q[idx] != '0;
				end
				REG_IRQ_STATUS: ;
				default:        rsp.status = ST_OFFSET;
			endcase
		end
		rsp.arm_warning = arm_try && !arm_seen_q[idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NUM_BANKS; b++) begin
				value_q[b]     <= '0;
				direction_q[b] <= '0;
				pull_q[b]      <= '0;
				irq_en_q[b]    <= '0;
				trig_lvl_q[b]  <= '0;
				trig_type_q[b] <= '0;
			end
			arm_seen_q <= '0;
		end else if (en) begin
			if (we_value) value_q[idx] <= (value_q[idx] & ~mask) | (lo & mask);
			if (we_dir)   direction_q[idx] <= lo;
			if (we_pull)  pull_q[idx] <= lo;
			if (we_irq)   irq_en_q[idx] <= lo;
			if (we_lvl)   trig_lvl_q[idx] <= lo;
			if (we_type)  trig_type_q[idx] <= lo;
			if (arm_try)  arm_seen_q[idx] <= 1'b1;
		end
	end

	// a bank once warned stays warned until reset
	`ASSERT_NEXT(a_arm_sticky, 1'b1, &(arm_seen_q | ~$past(arm_seen_q)), "arm flag cleared")
	// warning only on a successful access (status OK)
	`ASSERT_ALWAYS(a_warn_ok, !rsp.arm_warning || rsp.status == ST_OK, "warning on failed access")
	// failed accesses return zero data
	`ASSERT_ALWAYS(a_err_data, rsp.status == ST_OK || ~|rsp.read_data, "data on failed access")

endmodule
